/* rtl/apf_pkg.sv */
// apf_pkg: shared types, widths and the constant root table of the pattern factor pipeline
// depends on nothing; used by every apf module and the top level
`default_nettype none

package apf_pkg;

   localparam int COORD_W   = 16;
   localparam int DIV_STEPS = 32;
   localparam int LOG_STEPS = 30;
   localparam int EXP_STEPS = 30;

   // 1.15 in Q20
   localparam logic [20:0] SCALE_Q20 = 21'd1205862;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } vec_type;

   // travels with the data through every stage
   typedef struct packed {
      logic valid;
      logic kill;
   } tag_type;

   typedef logic [EXP_STEPS:1][31:0] root_tab_type;

   function automatic logic [63:0] isqrt64(input logic [63:0] v);
      logic [63:0] rem;
      logic [63:0] res;
      logic [63:0] bitv;
      rem  = v;
      res  = '0;
      bitv = 64'h4000_0000_0000_0000;
      for (int k = 0; k < 32; k++) begin
         if (bitv > rem) bitv = bitv >> 2;
      end
      for (int k = 0; k < 32; k++) begin
         if (bitv != 64'd0) begin
            if (rem >= res + bitv) begin
               rem = rem - (res + bitv);
               res = (res >> 1) + bitv;
            end else begin
               res = res >> 1;
            end
            bitv = bitv >> 2;
         end
      end
      return res;
   endfunction

   // entry i is 2^(-2^-i) in Q0.32
   function automatic root_tab_type build_roots();
      root_tab_type tab;
      logic [63:0] t;
      tab = '0;
      t = isqrt64(64'h8000_0000_0000_0000);
      tab[1] = t[31:0];
      for (int i = 2; i <= EXP_STEPS; i++) begin
         t = isqrt64({t[31:0], 32'h0});
         tab[i] = t[31:0];
      end
      return tab;
   endfunction

   localparam root_tab_type ROOT_TAB = build_roots();

endpackage

`default_nettype wire

/* rtl/apf_dot.sv */
// apf_dot: three dot products of the wave vector, sign test and magnitudes, three stages
// depends on apf_pkg
`default_nettype none

module apf_dot (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             adv,
   input  wire apf_pkg::tag_type in_tag,
   input  wire apf_pkg::vec_type k,
   input  wire apf_pkg::vec_type normal,
   input  wire apf_pkg::vec_type copol,
   input  wire apf_pkg::vec_type xpol,
   output apf_pkg::tag_type      out_tag,
   output logic [31:0]           a,
   output logic [1:0][31:0]      b
);

   logic signed [31:0] prod_in [0:8];
   logic signed [31:0] prod_ff [0:8];
   logic signed [33:0] sum_in  [0:2];
   logic signed [33:0] sum_ff  [0:2];
   logic signed [33:0] n_val;
   logic signed [33:0] c_abs;
   logic signed [33:0] x_abs;
   logic               n_le;
   logic [31:0]        a_ff;
   logic [1:0][31:0]   b_ff;
   apf_pkg::tag_type   tag_ff [1:3];
   apf_pkg::tag_type   tag3_in;

   always_comb begin
      prod_in[0] = k.x * normal.x;
      prod_in[1] = k.y * normal.y;
      prod_in[2] = k.z * normal.z;
      prod_in[3] = k.x * copol.x;
      prod_in[4] = k.y * copol.y;
      prod_in[5] = k.z * copol.z;
      prod_in[6] = k.x * xpol.x;
      prod_in[7] = k.y * xpol.y;
      prod_in[8] = k.z * xpol.z;
      for (int j = 0; j < 3; j++) begin
         sum_in[j] = 34'(prod_ff[3*j]) + 34'(prod_ff[3*j+1]) + 34'(prod_ff[3*j+2]);
      end
      n_val = -sum_ff[0];
      c_abs = sum_ff[1][33] ? -sum_ff[1] : sum_ff[1];
      x_abs = sum_ff[2][33] ? -sum_ff[2] : sum_ff[2];
      n_le  = n_val[33] | (n_val == 34'sd0);
      tag3_in.valid = tag_ff[2].valid;
      tag3_in.kill  = tag_ff[2].kill | n_le;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff <= prod_in;
         sum_ff  <= sum_in;
         a_ff    <= n_val[31:0];
         b_ff[0] <= c_abs[31:0];
         b_ff[1] <= x_abs[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 1; s <= 3; s++) tag_ff[s] <= '0;
      end else if (adv) begin
         tag_ff[1] <= in_tag;
         tag_ff[2] <= tag_ff[1];
         tag_ff[3] <= tag3_in;
      end
   end

   assign out_tag = tag_ff[3];
   assign a       = a_ff;
   assign b       = b_ff;

endmodule

`default_nettype wire

/* rtl/apf_ratio.sv */
// apf_ratio: two lanes of a^2/(a^2+b^2) in Q0.32, restoring division one bit per stage
// depends on apf_pkg
`default_nettype none

module apf_ratio (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             adv,
   input  wire apf_pkg::tag_type in_tag,
   input  wire logic [31:0]      a,
   input  wire logic [1:0][31:0] b,
   output apf_pkg::tag_type      out_tag,
   output logic [1:0][32:0]      r
);

   localparam int DIV   = apf_pkg::DIV_STEPS;
   localparam int DEPTH = 3 + DIV;

   apf_pkg::tag_type tag_ff [1:DEPTH];

   for (genvar l = 0; l < 2; l++) begin : g_lane
      logic              big;
      logic [30:0]       as_in;
      logic [30:0]       bs_in;
      logic [30:0]       as_ff;
      logic [30:0]       bs_ff;
      logic              one1_ff;
      logic [61:0]       asq_ff;
      logic [61:0]       bsq_ff;
      logic              one2_ff;
      logic [62:0]       rem_ff [0:DIV];
      logic [62:0]       den_ff [0:DIV];
      logic [31:0]       quo_ff [0:DIV];
      logic              one_ff [0:DIV];
      logic [62:0]       rem_in [0:DIV-1];
      logic              ge     [0:DIV-1];

      always_comb begin
         logic [63:0] sh;
         big   = a[31] | b[l][31];
         as_in = big ? a[31:1] : a[30:0];
         bs_in = big ? b[l][31:1] : b[l][30:0];
         for (int s = 0; s < DIV; s++) begin
            sh        = {rem_ff[s], 1'b0};
            ge[s]     = sh >= {1'b0, den_ff[s]};
            rem_in[s] = ge[s] ? 63'(sh - {1'b0, den_ff[s]}) : sh[62:0];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            as_ff     <= as_in;
            bs_ff     <= bs_in;
            one1_ff   <= (bs_in == 31'd0);
            asq_ff    <= 62'(as_ff) * 62'(as_ff);
            bsq_ff    <= 62'(bs_ff) * 62'(bs_ff);
            one2_ff   <= one1_ff;
            rem_ff[0] <= {1'b0, asq_ff};
            den_ff[0] <= 63'(asq_ff) + 63'(bsq_ff);
            quo_ff[0] <= '0;
            one_ff[0] <= one2_ff;
            for (int s = 0; s < DIV; s++) begin
               rem_ff[s+1] <= rem_in[s];
               den_ff[s+1] <= den_ff[s];
               quo_ff[s+1] <= {quo_ff[s][30:0], ge[s]};
               one_ff[s+1] <= one_ff[s];
            end
         end
      end

      // exact one when b vanishes after the range shift
      assign r[l] = one_ff[DIV] ? 33'h1_0000_0000 : {1'b0, quo_ff[DIV]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 1; s <= DEPTH; s++) tag_ff[s] <= '0;
      end else if (adv) begin
         tag_ff[1] <= in_tag;
         for (int s = 2; s <= DEPTH; s++) tag_ff[s] <= tag_ff[s-1];
      end
   end

   assign out_tag = tag_ff[DEPTH];

endmodule

`default_nettype wire

/* rtl/apf_log.sv */
// apf_log: two lanes of -log2 in Q30, normalize then one square-and-compare per stage
// depends on apf_pkg
`default_nettype none

module apf_log (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             adv,
   input  wire apf_pkg::tag_type in_tag,
   input  wire logic [1:0][32:0] r,
   output apf_pkg::tag_type      out_tag,
   output logic [1:0][35:0]      neglog
);

   localparam int LOG   = apf_pkg::LOG_STEPS;
   localparam int DEPTH = 1 + LOG;

   apf_pkg::tag_type tag_ff [1:DEPTH];
   apf_pkg::tag_type tag1_in;

   always_comb begin
      tag1_in.valid = in_tag.valid;
      tag1_in.kill  = in_tag.kill | (r[0] == 33'd0) | (r[1] == 33'd0);
   end

   for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [5:0]  msb;
      logic [31:0] m_in;
      logic [31:0] m_ff    [0:LOG];
      logic [5:0]  e_ff    [0:LOG];
      logic [29:0] frac_ff [0:LOG];
      logic [31:0] mstep   [0:LOG-1];
      logic        hi      [0:LOG-1];

      always_comb begin
         logic [63:0] sq;
         logic [32:0] t;
         msb = '0;
         for (int i = 0; i < 33; i++) begin
            if (r[l][i]) msb = 6'(i);
         end
         m_in = (msb <= 6'd31) ? (r[l][31:0] << 5'(6'd31 - msb)) : r[l][32:1];
         for (int s = 0; s < LOG; s++) begin
            sq       = 64'(m_ff[s]) * 64'(m_ff[s]);
            t        = sq[63:31];
            hi[s]    = t[32];
            mstep[s] = t[32] ? t[32:1] : t[31:0];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            m_ff[0]    <= m_in;
            e_ff[0]    <= 6'd32 - msb;
            frac_ff[0] <= '0;
            for (int s = 0; s < LOG; s++) begin
               m_ff[s+1]    <= mstep[s];
               e_ff[s+1]    <= e_ff[s];
               frac_ff[s+1] <= {frac_ff[s][28:0], hi[s]};
            end
         end
      end

      assign neglog[l] = {e_ff[LOG], 30'd0} - {6'd0, frac_ff[LOG]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 1; s <= DEPTH; s++) tag_ff[s] <= '0;
      end else if (adv) begin
         tag_ff[1] <= tag1_in;
         for (int s = 2; s <= DEPTH; s++) tag_ff[s] <= tag_ff[s-1];
      end
   end

   assign out_tag = tag_ff[DEPTH];

endmodule

`default_nettype wire

/* rtl/apf_exp.sv */
// apf_exp: sum and 1.15 scale of the logs, exp2 by root table, rounding to Q1.15
// depends on apf_pkg (root table, scale constant)
`default_nettype none

module apf_exp (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             adv,
   input  wire apf_pkg::tag_type in_tag,
   input  wire logic [1:0][35:0] neglog,
   output apf_pkg::tag_type      out_tag,
   output logic [15:0]           pattern_factor
);

   localparam int EXP   = apf_pkg::EXP_STEPS;
   localparam int DEPTH = 4 + EXP;

   apf_pkg::tag_type tag_ff [1:DEPTH];
   apf_pkg::tag_type tag3_in;
   apf_pkg::tag_type tag_out_in;

   logic [36:0] mag_ff;
   logic [57:0] prod_ff;
   logic [57:0] rnd;
   logic [37:0] p_val;
   logic        q_big;
   logic [32:0] acc_ff [0:EXP];
   logic [29:0] f_ff   [0:EXP];
   logic [4:0]  q_ff   [0:EXP];
   logic [32:0] acc_in [0:EXP-1];
   logic [48:0] rsum;
   logic [48:0] rshift;
   logic [15:0] pf_in;
   logic [15:0] pf_ff;

   always_comb begin
      logic [64:0] mp;
      rnd   = prod_ff + 58'(1 << 19);
      p_val = rnd[57:20];
      q_big = |p_val[37:35];
      tag3_in.valid = tag_ff[2].valid;
      tag3_in.kill  = tag_ff[2].kill | q_big;
      for (int s = 0; s < EXP; s++) begin
         mp = 65'(acc_ff[s]) * 65'(apf_pkg::ROOT_TAB[s+1]);
         acc_in[s] = f_ff[s][29-s] ? mp[64:32] : acc_ff[s];
      end
      rsum   = 49'(acc_ff[EXP]) + (49'd1 << (6'd16 + 6'(q_ff[EXP])));
      rshift = rsum >> (6'd17 + 6'(q_ff[EXP]));
      pf_in  = tag_ff[DEPTH-1].kill ? 16'd0 : rshift[15:0];
      tag_out_in = tag_ff[DEPTH-1];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mag_ff    <= 37'(neglog[0]) + 37'(neglog[1]);
         prod_ff   <= 58'(mag_ff) * 58'(apf_pkg::SCALE_Q20);
         acc_ff[0] <= 33'h1_0000_0000;
         f_ff[0]   <= p_val[29:0];
         q_ff[0]   <= p_val[34:30];
         for (int s = 0; s < EXP; s++) begin
            acc_ff[s+1] <= acc_in[s];
            f_ff[s+1]   <= f_ff[s];
            q_ff[s+1]   <= q_ff[s];
         end
         pf_ff <= pf_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 1; s <= DEPTH; s++) tag_ff[s] <= '0;
      end else if (adv) begin
         tag_ff[1] <= in_tag;
         tag_ff[2] <= tag_ff[1];
         tag_ff[3] <= tag3_in;
         for (int s = 4; s < DEPTH; s++) tag_ff[s] <= tag_ff[s-1];
         tag_ff[DEPTH] <= tag_out_in;
      end
   end

   assign out_tag        = tag_ff[DEPTH];
   assign pattern_factor = pf_ff;

endmodule

`default_nettype wire

/* rtl/antenna_pattern_factor_top.sv */
// antenna_pattern_factor_top: pattern factor of a receive element from the incident wave vector
// depends on apf_pkg, apf_dot, apf_ratio, apf_log, apf_exp
//
// Takes the wave vector k and the element's normal, co-pol and cross-pol vectors (signed
// Q2.14) and returns (n^2/(n^2+c^2))^1.15 * (n^2/(n^2+x^2))^1.15 as unsigned Q1.15, where
// n = -(k.normal), c = k.copol, x = k.xpol; zero when n is not positive, when a ratio
// truncates to zero, or when the factor falls below 2^-32. One request is accepted every
// cycle while the pipeline is not held, and each result passes through its stages in order: 3
// stages of dot products, 35 for the two ratios (32 of them one division bit each), 31
// for the two logarithms (one squaring each), and 34 for scaling, 30 exp2 steps from
// the root table and the rounding output register. The whole pipeline moves as one;
// it holds only while a result sits in the output register and rsp_ready is low, so
// nothing is dropped or repeated under back pressure.
`default_nettype none

module antenna_pattern_factor_top (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [15:0] req_k_x,
   input  wire logic [15:0] req_k_y,
   input  wire logic [15:0] req_k_z,
   input  wire logic [15:0] req_normal_x,
   input  wire logic [15:0] req_normal_y,
   input  wire logic [15:0] req_normal_z,
   input  wire logic [15:0] req_copol_x,
   input  wire logic [15:0] req_copol_y,
   input  wire logic [15:0] req_copol_z,
   input  wire logic [15:0] req_xpol_x,
   input  wire logic [15:0] req_xpol_y,
   input  wire logic [15:0] req_xpol_z,
   // result channel
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [15:0]      rsp_pattern_factor
);

   apf_pkg::vec_type k_vec;
   apf_pkg::vec_type normal_vec;
   apf_pkg::vec_type copol_vec;
   apf_pkg::vec_type xpol_vec;
   apf_pkg::tag_type req_tag;
   apf_pkg::tag_type dot_tag;
   apf_pkg::tag_type ratio_tag;
   apf_pkg::tag_type log_tag;
   apf_pkg::tag_type out_tag;

   logic             adv;
   logic [31:0]      dot_a;
   logic [1:0][31:0] dot_b;
   logic [1:0][32:0] ratio_r;
   logic [1:0][35:0] log_val;

   // global pipeline advance: the output slot is free or being taken
   assign adv       = ~out_tag.valid | rsp_ready;
   assign req_ready = adv;

   always_comb begin
      k_vec      = '{x: req_k_x,      y: req_k_y,      z: req_k_z};
      normal_vec = '{x: req_normal_x, y: req_normal_y, z: req_normal_z};
      copol_vec  = '{x: req_copol_x,  y: req_copol_y,  z: req_copol_z};
      xpol_vec   = '{x: req_xpol_x,   y: req_xpol_y,   z: req_xpol_z};
      // stage registers load only on adv, so valid here marks an accepted request
      req_tag.valid = req_valid;
      req_tag.kill  = 1'b0;
   end

   // dot products, sign test of n, magnitudes of c and x
   apf_dot u_dot (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .in_tag  (req_tag),
      .k       (k_vec),
      .normal  (normal_vec),
      .copol   (copol_vec),
      .xpol    (xpol_vec),
      .out_tag (dot_tag),
      .a       (dot_a),
      .b       (dot_b)
   );

   // co-pol and cross-pol ratios side by side
   apf_ratio u_ratio (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .in_tag  (dot_tag),
      .a       (dot_a),
      .b       (dot_b),
      .out_tag (ratio_tag),
      .r       (ratio_r)
   );

   // negative base-2 logs of both ratios
   apf_log u_log (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .in_tag  (ratio_tag),
      .r       (ratio_r),
      .out_tag (log_tag),
      .neglog  (log_val)
   );

   // 2^(-1.15 * sum) and rounding; last register is the output register
   apf_exp u_exp (
      .clock          (clock),
      .reset          (reset),
      .adv            (adv),
      .in_tag         (log_tag),
      .neglog         (log_val),
      .out_tag        (out_tag),
      .pattern_factor (rsp_pattern_factor)
   );

   assign rsp_valid = out_tag.valid;

endmodule

`default_nettype wire

/* sim/tb_antenna_pattern_factor_top.sv */
// tb_antenna_pattern_factor_top: self-checking bench for the antenna pattern factor pipeline
// depends on antenna_pattern_factor_top and apf_pkg; predicts each factor in fixed point
`default_nettype none

module tb_antenna_pattern_factor_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PIPE_LATENCY = 103;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_COUNT = 1200;

   typedef struct {
      logic [15:0] k [3];
      logic [15:0] nrm [3];
      logic [15:0] co [3];
      logic [15:0] xp [3];
   } wave_req_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [15:0] req_k_x = '0, req_k_y = '0, req_k_z = '0;
   logic [15:0] req_normal_x = '0, req_normal_y = '0, req_normal_z = '0;
   logic [15:0] req_copol_x = '0, req_copol_y = '0, req_copol_z = '0;
   logic [15:0] req_xpol_x = '0, req_xpol_y = '0, req_xpol_z = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [15:0] rsp_pattern_factor;

   antenna_pattern_factor_top u_top (
      .clock, .reset, .req_valid, .req_ready,
      .req_k_x, .req_k_y, .req_k_z,
      .req_normal_x, .req_normal_y, .req_normal_z,
      .req_copol_x, .req_copol_y, .req_copol_z,
      .req_xpol_x, .req_xpol_y, .req_xpol_z,
      .rsp_valid, .rsp_ready, .rsp_pattern_factor
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   wave_req_type pending_reqs[$];
   logic [15:0]  expected_factors[$];
   logic [31:0]  root_q32 [31];
   int           mismatch_count = 0;
   int           cycle_count = 0;
   int           accepted_reqs = 0;
   int           zero_factors = 0;
   int           checked_factors = 0;
   bit           calm_tail = 1'b0;  // no idling in the last part
   bit           hold_rsp = 1'b0;   // long receiver hold-off
   bit           stim_done = 1'b0;

   // floor square root of a 64-bit value
   function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
      logic [63:0] res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   // square-root chain giving 2^(-2^-i) in Q0.32
   task automatic fill_roots();
      logic [63:0] t;
      t = floor_sqrt(64'd1 << 63);
      root_q32[1] = t[31:0];
      for (int i = 2; i <= 30; i++) begin
         t = floor_sqrt({t[31:0], 32'h0});
         root_q32[i] = t[31:0];
      end
   endtask

   function automatic longint dot_q28(input logic [15:0] a[3], input logic [15:0] b[3]);
      longint s;
      s = 0;
      for (int i = 0; i < 3; i++)
         s += longint'($signed(a[i])) * longint'($signed(b[i]));
      return s;
   endfunction

   // n^2/(n^2+b^2) in Q0.32, truncated
   function automatic logic [63:0] power_ratio(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] num, den, rem, q;
      if (a >= 64'h8000_0000 || b >= 64'h8000_0000) begin
         a = a >> 1;
         b = b >> 1;
      end
      if (b == 0) return 64'd1 << 32;
      num = a * a;
      den = num + b * b;
      rem = num;
      q = 0;
      for (int i = 0; i < 32; i++) begin
         rem = rem << 1;
         q = q << 1;
         if (rem >= den) begin
            rem = rem - den;
            q = q | 64'd1;
         end
      end
      return q;
   endfunction

   // -log2(r / 2^32) in Q30
   function automatic logic [63:0] neg_log2(input logic [63:0] r);
      int msb;
      logic [63:0] m, frac;
      msb = 32;
      frac = 0;
      while (msb > 0 && r[msb] == 1'b0) msb--;
      m = (msb <= 31) ? (r << (31 - msb)) : (r >> 1);
      for (int i = 0; i < 30; i++) begin
         m = (m * m) >> 31;
         frac = frac << 1;
         if (m >= (64'd1 << 32)) begin
            m = m >> 1;
            frac = frac | 64'd1;
         end
      end
      return (64'(32 - msb) << 30) - frac;
   endfunction

   function automatic logic [15:0] pattern_gain(input wave_req_type w);
      longint n, c, x;
      logic [63:0] r1, r2, mag, p, f, acc;
      int q;
      n = -dot_q28(w.k, w.nrm);
      c = dot_q28(w.k, w.co);
      x = dot_q28(w.k, w.xp);
      if (n <= 0) return 16'd0;
      r1 = power_ratio(n, c < 0 ? -c : c);
      r2 = power_ratio(n, x < 0 ? -x : x);
      if (r1 == 0 || r2 == 0) return 16'd0;
      mag = neg_log2(r1) + neg_log2(r2);
      p = (mag * 64'd1205862 + (64'd1 << 19)) >> 20;
      q = int'(p >> 30);
      f = p & ((64'd1 << 30) - 1);
      if (q >= 32) return 16'd0;
      acc = 64'd1 << 32;
      for (int i = 1; i <= 30; i++)
         if (f[30-i]) acc = (acc * root_q32[i]) >> 32;
      return 16'((acc + (64'd1 << (16 + q))) >> (17 + q));
   endfunction

   function automatic logic [15:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'(int'($urandom_range(0, 64)) - 32);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic wave_req_type make_req(input int k0, k1, k2, n0, n1, n2,
                                             c0, c1, c2, x0, x1, x2);
      wave_req_type w;
      w.k = '{16'(k0), 16'(k1), 16'(k2)};
      w.nrm = '{16'(n0), 16'(n1), 16'(n2)};
      w.co = '{16'(c0), 16'(c1), 16'(c2)};
      w.xp = '{16'(x0), 16'(x1), 16'(x2)};
      return w;
   endfunction

   // mostly plausible geometry: wave roughly against the normal, orthogonal-ish pols
   function automatic wave_req_type rand_req();
      wave_req_type w;
      int s;
      if ($urandom_range(0, 9) < 2) begin
         for (int i = 0; i < 3; i++) begin
            w.k[i] = rand_coord(); w.nrm[i] = rand_coord();
            w.co[i] = rand_coord(); w.xp[i] = rand_coord();
         end
      end else begin
         s = 16384;
         w.k = '{16'($urandom_range(0, 16000) - 8000), 16'($urandom_range(0, 16000) - 8000),
                 16'(-int'($urandom_range(0, s)))};
         w.nrm = '{16'($urandom_range(0, 2000) - 1000), 16'($urandom_range(0, 2000) - 1000),
                   16'(s - int'($urandom_range(0, 3000)))};
         w.co = '{16'(s - int'($urandom_range(0, 3000))), 16'($urandom_range(0, 2000) - 1000),
                  16'($urandom_range(0, 2000) - 1000)};
         w.xp = '{16'($urandom_range(0, 2000) - 1000), 16'(s - int'($urandom_range(0, 3000))),
                  16'($urandom_range(0, 2000) - 1000)};
      end
      return w;
   endfunction

   initial begin
      fill_roots();
      // boresight, exact 1.0
      pending_reqs.push_back(make_req(0, 0, -16384, 0, 0, 16384, 16384, 0, 0, 0, 16384, 0));
      // wave from behind and grazing
      pending_reqs.push_back(make_req(0, 0, 16384, 0, 0, 16384, 16384, 0, 0, 0, 16384, 0));
      pending_reqs.push_back(make_req(16384, 0, 0, 0, 0, 16384, 16384, 0, 0, 0, 16384, 0));
      // 45 degrees in each plane
      pending_reqs.push_back(make_req(11585, 0, -11585, 0, 0, 16384, 16384, 0, 0, 0, 16384, 0));
      pending_reqs.push_back(make_req(0, 11585, -11585, 0, 0, 16384, 16384, 0, 0, 0, 16384, 0));
      // tiny n with huge c: ratio truncates to zero / very small factor
      pending_reqs.push_back(make_req(32767, 0, -1, 0, 0, 1, 32767, 0, 0, 0, 32767, 0));
      pending_reqs.push_back(make_req(200, 0, -1, 0, 0, 300, 32767, 0, 0, 0, 32767, 0));
      // extremes: all most negative / all most positive, max dot magnitudes
      pending_reqs.push_back(make_req(-32768, -32768, -32768, 32767, 32767, 32767,
                                      -32768, -32768, -32768, -32768, -32768, -32768));
      pending_reqs.push_back(make_req(-32768, -32768, -32768, 32767, 32767, 32767,
                                      0, 0, 0, 0, 0, 0));
      pending_reqs.push_back(make_req(32767, 32767, 32767, -32768, -32768, -32768,
                                      32767, -32768, 1, -1, 32767, -32768));
      pending_reqs.push_back(make_req(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      pending_reqs.push_back(make_req(-1, -1, -1, 1, 1, 1, -1, 1, -1, 1, -1, 1));
      // non unit vectors
      pending_reqs.push_back(make_req(-300, 5000, -20000, 123, -4000, 32000,
                                      30000, 77, -9, 3, 29000, -500));
      for (int i = 0; i < RANDOM_COUNT; i++) pending_reqs.push_back(rand_req());
   end

   // sender idle bursts
   int req_idle = 0;

   // driver: changes at the falling edge, handshake sampled from the rising edge
   bit req_taken = 1'b0;
   always @(posedge clock) req_taken <= req_valid && req_ready && !reset;

   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && !req_taken) begin
            // still offered, hold payload
         end else if (req_idle > 0) begin
            req_idle <= req_idle - 1;
            req_valid <= 1'b0;
         end else if (!calm_tail && $urandom_range(0, 15) == 0) begin
            req_idle <= $urandom_range(1, 8) - 1;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            wave_req_type w;
            w = pending_reqs.pop_front();
            req_k_x <= w.k[0]; req_k_y <= w.k[1]; req_k_z <= w.k[2];
            req_normal_x <= w.nrm[0]; req_normal_y <= w.nrm[1]; req_normal_z <= w.nrm[2];
            req_copol_x <= w.co[0]; req_copol_y <= w.co[1]; req_copol_z <= w.co[2];
            req_xpol_x <= w.xp[0]; req_xpol_y <= w.xp[1]; req_xpol_z <= w.xp[2];
            expected_factors.push_back(pattern_gain(w));
            req_valid <= 1'b1;
            if (pending_reqs.size() < 150) calm_tail <= 1'b1;
         end else begin
            req_valid <= 1'b0;
            stim_done <= 1'b1;
         end
      end
   end

   // receiver ready: random stall bursts plus one long hold-off
   int rsp_idle = 0;
   always @(negedge clock) begin
      if (reset || hold_rsp) begin
         rsp_ready <= 1'b0;
      end else if (rsp_idle > 0) begin
         rsp_idle <= rsp_idle - 1;
         rsp_ready <= 1'b0;
      end else if (!calm_tail && $urandom_range(0, 11) == 0) begin
         rsp_idle <= $urandom_range(1, 8) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // long hold-off once the pipeline has had time to fill
   initial begin
      int held;
      held = 0;
      wait (accepted_reqs >= 300);
      @(negedge clock);
      hold_rsp = 1'b1;
      while (held < 400) begin
         @(negedge clock);
         held++;
      end
      hold_rsp = 1'b0;
   end

   // monitor: compare each delivered factor with the oldest prediction
   always @(posedge clock) begin
      logic [15:0] want;
      cycle_count <= cycle_count + 1;
      if (!reset) begin
         if (req_valid && req_ready) accepted_reqs <= accepted_reqs + 1;
         if (rsp_valid && rsp_ready) begin
            if (expected_factors.size() == 0) begin
               mismatch_count <= mismatch_count + 1;
               if (mismatch_count < 10)
                  $display("unexpected result %0d with nothing pending", rsp_pattern_factor);
            end else begin
               want = expected_factors.pop_front();
               checked_factors <= checked_factors + 1;
               if (want == 16'd0) zero_factors <= zero_factors + 1;
               if (rsp_pattern_factor !== want) begin
                  mismatch_count <= mismatch_count + 1;
                  if (mismatch_count < 10)
                     $display("pattern_factor mismatch: expected %0d got %0d",
                              want, rsp_pattern_factor);
               end
            end
         end
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      fork
         begin
            wait (stim_done && expected_factors.size() == 0);
            repeat (PIPE_LATENCY + 20) @(posedge clock);
         end
         begin
            wait (cycle_count >= CYCLE_LIMIT);
            $display("timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
         end
      join_any
      $display("checked %0d pattern factors (%0d zero), incl. a %0d-cycle output hold-off",
               checked_factors, zero_factors, 400);
      if (mismatch_count == 0 && expected_factors.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

`default_nettype wire
